// ----- design/variable_length_record_ring_top_assert.svh -----
// Assertion macros used by the record ring checker.
`ifndef VARIABLE_LENGTH_RECORD_RING_TOP_ASSERT_SVH
`define VARIABLE_LENGTH_RECORD_RING_TOP_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define VLRR_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define VLRR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/vlrr_pkg.sv -----
// Types, codes and constants for the variable-length record ring.
package vlrr_pkg;

    localparam int LEN_W            = 13;
    localparam int PAD_W            = 14;
    localparam int DATA_W           = 32;
    localparam int CNT_W            = 11;
    localparam int HDR_BYTES        = 4;
    localparam int MIN_RING_BYTES   = 8;
    localparam int RESET_RING_BYTES = 4096;
    localparam int DEF_RING_BYTES   = 4096;
    localparam int Q_DEPTH          = 2;

    typedef enum logic [1:0] {
        OP_BEGIN_PUSH = 2'd0,
        OP_PUSH_WORD  = 2'd1,
        OP_BEGIN_POP  = 2'd2,
        OP_POP_WORD   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_BYPASS  = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_SEQ_ERR = 3'd4
    } t_status;

    // Classified command word, front to back.
    typedef struct packed {
        t_op                op;
        logic [LEN_W-1:0]   len;
        logic [PAD_W-1:0]   padded;
        logic               zero_len;
        logic               oversize;
        logic [DATA_W-1:0]  data;
    } t_cmd;

    // Result word, back to ports.
    typedef struct packed {
        logic               done;
        t_status            status;
        logic [DATA_W-1:0]  data;
        logic [LEN_W-1:0]   len;
        logic               last;
        logic [LEN_W-1:0]   used;
        logic [CNT_W-1:0]   pending;
    } t_res;

endpackage

// ----- design/variable_length_record_ring_top.sv -----
// Top level of the variable-length record ring.
//
//  channel   direction  handshake                     payload
//  command   in         start & !busy                 i_opcode, i_length_bytes, i_data_word
//  result    out        o_done (one-cycle strobe)     o_status, o_data_out, o_length_out,
//                                                     o_last_word, o_used_bytes,
//                                                     o_pending_messages
//  config    in         i_cfg_we                      i_cfg_wdata (ring size in bytes)
//
// Sustained rate is one word per cycle; the result strobe follows the taken word
// through the queue slot, memory read and result register.
// The back end retires a word every cycle through its single registered read
// port and write port, so the queue never fills and busy stays low.
// Synchronous active-low reset empties the ring; memory contents are left as is.
// A config write also empties the ring. The receiver cannot stall results.
module variable_length_record_ring_top #(
    parameter int  RING_BYTES = vlrr_pkg::DEF_RING_BYTES,
    localparam int OW         = $clog2(RING_BYTES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_opcode,
    input  logic [vlrr_pkg::LEN_W-1:0]    i_length_bytes,
    input  logic [vlrr_pkg::DATA_W-1:0]   i_data_word,
    input  logic                          i_cfg_we,
    input  logic [vlrr_pkg::LEN_W-1:0]    i_cfg_wdata,
    output logic                          o_done,
    output logic [2:0]                    o_status,
    output logic [vlrr_pkg::DATA_W-1:0]   o_data_out,
    output logic [vlrr_pkg::LEN_W-1:0]    o_length_out,
    output logic                          o_last_word,
    output logic [vlrr_pkg::LEN_W-1:0]    o_used_bytes,
    output logic [vlrr_pkg::CNT_W-1:0]    o_pending_messages
);
    import vlrr_pkg::*;

    localparam int SW        = ((OW > LEN_W) ? OW : LEN_W) + 1;
    localparam int MEM_BYTES = (RING_BYTES / 4) * 4;

    logic [LEN_W-1:0] r_ring_bytes;
    logic [OW-1:0]    size;
    logic [SW-1:0]    size_raw;

    logic             push;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    t_cmd             front_cmd;
    t_cmd             q_cmd;
    t_res             res;

    // ring size register; low two bits dropped, then clamped to MIN_RING_BYTES and the memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_bytes <= LEN_W'(RESET_RING_BYTES);
        end else if (i_cfg_we) begin
            r_ring_bytes <= i_cfg_wdata;
        end
    end

    always_comb begin
        size_raw = SW'({r_ring_bytes[LEN_W-1:2], 2'b00});
        if (size_raw < SW'(MIN_RING_BYTES)) begin
            size_raw = SW'(MIN_RING_BYTES);
        end
        if (size_raw > SW'(MEM_BYTES)) begin
            size_raw = SW'(MEM_BYTES);
        end
        size = OW'(size_raw);
    end

    vlrr_front #(
        .RING_BYTES (RING_BYTES)
    ) u_front (
        .start          (start),
        .i_q_full       (q_full),
        .i_opcode       (i_opcode),
        .i_length_bytes (i_length_bytes),
        .i_data_word    (i_data_word),
        .i_size         (size),
        .o_busy         (busy),
        .o_push         (push),
        .o_cmd          (front_cmd)
    );

    vlrr_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_cmd   (q_cmd)
    );

    // a config write must arrive only while idle (the block does not enforce it); it clears all pointers
    vlrr_back #(
        .RING_BYTES (RING_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (i_cfg_we),
        .i_size    (size),
        .i_q_empty (q_empty),
        .i_cmd     (q_cmd),
        .o_q_pop   (q_pop),
        .o_res     (res)
    );

    assign o_done             = res.done;
    assign o_status           = res.status;
    assign o_data_out         = res.data;
    assign o_length_out       = res.len;
    assign o_last_word        = res.last;
    assign o_used_bytes       = res.used;
    assign o_pending_messages = res.pending;

endmodule

// ----- design/vlrr_front.sv -----
// Front end: takes command words and classifies them for the back end.
module vlrr_front #(
    parameter int  RING_BYTES = vlrr_pkg::DEF_RING_BYTES,
    localparam int OW         = $clog2(RING_BYTES + 1)
) (
    input  logic                          start,
    input  logic                          i_q_full,
    input  logic [1:0]                    i_opcode,
    input  logic [vlrr_pkg::LEN_W-1:0]    i_length_bytes,
    input  logic [vlrr_pkg::DATA_W-1:0]   i_data_word,
    input  logic [OW-1:0]                 i_size,
    output logic                          o_busy,
    output logic                          o_push,
    output vlrr_pkg::t_cmd                o_cmd
);
    import vlrr_pkg::*;

    localparam int SW = ((OW > LEN_W) ? OW : LEN_W) + 1;

    logic [PAD_W-1:0] padded;

    // round payload up to whole words
    assign padded = (PAD_W'(i_length_bytes) + PAD_W'(3)) & ~PAD_W'(3);

    assign o_busy = i_q_full;
    assign o_push = start && !i_q_full;

    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = t_op'(i_opcode);
        o_cmd.len      = i_length_bytes;
        o_cmd.padded   = padded;
        o_cmd.zero_len = (i_length_bytes == '0);
        o_cmd.oversize = (SW'(i_length_bytes) + SW'(HDR_BYTES)) > SW'(i_size);
        o_cmd.data     = i_data_word;
    end

endmodule

// ----- design/vlrr_queue.sv -----
// Short command queue between front and back end.
module vlrr_queue #(
    parameter int DEPTH = vlrr_pkg::Q_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  vlrr_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_empty,
    output logic            o_full,
    output vlrr_pkg::t_cmd  o_cmd
);
    import vlrr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_slot [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_cmd   = r_slot[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

endmodule

// ----- design/vlrr_back.sv -----
// Back end: ring state, word memory and command execution.
module vlrr_back #(
    parameter int  RING_BYTES = vlrr_pkg::DEF_RING_BYTES,
    localparam int OW         = $clog2(RING_BYTES + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  logic [OW-1:0]   i_size,
    input  logic            i_q_empty,
    input  vlrr_pkg::t_cmd  i_cmd,
    output logic            o_q_pop,
    output vlrr_pkg::t_res  o_res
);
    import vlrr_pkg::*;

    localparam int MEM_WORDS = RING_BYTES / 4;
    localparam int AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int SW        = ((OW > LEN_W) ? OW : LEN_W) + 1;

    logic [DATA_W-1:0] mem [MEM_WORDS];

    logic [OW-1:0]     r_head, n_head;
    logic [OW-1:0]     r_tail, n_tail;
    logic [OW-1:0]     r_wp,   n_wp;
    logic [OW-1:0]     r_rp,   n_rp;
    logic [CNT_W-1:0]  r_wtw,  n_wtw;
    logic [CNT_W-1:0]  r_wtr,  n_wtr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_act;
    t_cmd              r_cmd;
    t_res              r_res, n_res;

    logic [DATA_W-1:0] r_rdata;
    logic [DATA_W-1:0] r_bypd;
    logic              r_byp;
    logic [DATA_W-1:0] rdata;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [AW-1:0]     raddr;

    assign o_q_pop = !i_q_empty;
    assign o_res   = r_res;
    // write in the same cycle as the read wins
    assign rdata   = r_byp ? r_bypd : r_rdata;

    always_comb begin
        logic [SW-1:0]    s_size;
        logic [SW-1:0]    s_head;
        logic [SW-1:0]    s_tail;
        logic [SW-1:0]    s_need;
        logic [SW-1:0]    s_nt;
        logic [SW-1:0]    s_rp;
        logic [LEN_W-1:0] rlen;
        logic [PAD_W-1:0] rpad;
        logic             contig;
        logic             full;

        s_size  = SW'(i_size);
        s_head  = SW'(r_head);
        s_tail  = SW'(r_tail);
        s_need  = SW'(HDR_BYTES) + SW'(r_cmd.padded);
        s_nt    = '0;
        s_rp    = '0;
        rlen    = rdata[LEN_W-1:0];
        rpad    = (PAD_W'(rlen) + PAD_W'(3)) & ~PAD_W'(3);
        contig  = 1'b0;
        full    = 1'b0;

        n_head  = r_head;
        n_tail  = r_tail;
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_wtw   = r_wtw;
        n_wtr   = r_wtr;
        n_count = r_count;
        we      = 1'b0;
        waddr   = r_tail[AW+1:2];
        wdata   = DATA_W'(r_cmd.len);
        n_res   = '0;
        n_res.status = ST_OK;

        if (r_act) begin
            case (r_cmd.op)
                OP_BEGIN_PUSH: begin
                    if (r_wtw != '0) begin
                        n_res.status = ST_SEQ_ERR;
                    end else if (r_cmd.oversize) begin
                        n_res.status = ST_BYPASS;
                    end else begin
                        contig = (s_tail + SW'(HDR_BYTES) + SW'(r_cmd.len)) <= s_size;
                        if (contig) begin
                            s_nt = s_tail + s_need;
                            if (s_nt == s_size) begin
                                s_nt = '0;
                            end
                            full = (s_head > s_tail) ? ((s_head - s_tail) <= s_need)
                                                     : (s_nt == s_head);
                        end else begin
                            // payload wraps to offset zero, header stays at tail
                            s_nt = SW'(r_cmd.padded);
                            full = (s_head > s_tail) || (SW'(r_cmd.padded) >= s_head);
                        end
                        if (full) begin
                            n_res.status = ST_FULL;
                        end else begin
                            we     = 1'b1;
                            n_wp   = contig ? OW'(s_tail + SW'(HDR_BYTES)) : '0;
                            n_wtw  = CNT_W'(r_cmd.padded >> 2);
                            n_tail = OW'(s_nt);
                            if (r_cmd.zero_len) begin
                                n_count    = r_count + 1'b1;
                                n_res.last = 1'b1;
                            end
                        end
                    end
                end
                OP_PUSH_WORD: begin
                    if (r_wtw == '0) begin
                        n_res.status = ST_SEQ_ERR;
                    end else begin
                        we    = 1'b1;
                        waddr = r_wp[AW+1:2];
                        wdata = r_cmd.data;
                        n_wp  = r_wp + OW'(HDR_BYTES);
                        n_wtw = r_wtw - 1'b1;
                        if (r_wtw == CNT_W'(1)) begin
                            n_count    = r_count + 1'b1;
                            n_res.last = 1'b1;
                        end
                    end
                end
                OP_BEGIN_POP: begin
                    if (r_wtr != '0) begin
                        n_res.status = ST_SEQ_ERR;
                    end else if (r_count == '0) begin
                        n_res.status = ST_EMPTY;
                    end else begin
                        s_rp = ((s_head + SW'(HDR_BYTES) + SW'(rlen)) <= s_size)
                             ? (s_head + SW'(HDR_BYTES)) : '0;
                        n_rp      = OW'(s_rp);
                        n_wtr     = CNT_W'(rpad >> 2);
                        n_count   = r_count - 1'b1;
                        n_res.len = rlen;
                        if (rlen == '0) begin
                            n_head     = (s_rp >= s_size) ? '0 : OW'(s_rp);
                            n_res.last = 1'b1;
                        end
                    end
                end
                OP_POP_WORD: begin
                    if (r_wtr == '0) begin
                        n_res.status = ST_SEQ_ERR;
                    end else begin
                        n_res.data = rdata;
                        n_rp       = r_rp + OW'(HDR_BYTES);
                        n_wtr      = r_wtr - 1'b1;
                        if (r_wtr == CNT_W'(1)) begin
                            n_head     = (SW'(n_rp) >= s_size) ? '0 : n_rp;
                            n_res.last = 1'b1;
                        end
                    end
                end
                default: begin
                    n_res.status = ST_SEQ_ERR;
                end
            endcase
        end

        n_res.done    = r_act;
        n_res.pending = n_count;
        n_res.used    = (n_head <= n_tail)
                      ? LEN_W'(SW'(n_tail) - SW'(n_head))
                      : LEN_W'(s_size - SW'(n_head) + SW'(n_tail));

        // next read follows the state this cycle leaves behind
        raddr = (i_cmd.op == OP_POP_WORD) ? n_rp[AW+1:2] : n_head[AW+1:2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_wp    <= '0;
            r_rp    <= '0;
            r_wtw   <= '0;
            r_wtr   <= '0;
            r_count <= '0;
            r_act   <= 1'b0;
            r_res   <= '0;
        end else begin
            r_act <= o_q_pop;
            r_res <= n_res;
            if (i_clear) begin
                r_head  <= '0;
                r_tail  <= '0;
                r_wp    <= '0;
                r_rp    <= '0;
                r_wtw   <= '0;
                r_wtr   <= '0;
                r_count <= '0;
            end else begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_wp    <= n_wp;
                r_rp    <= n_rp;
                r_wtw   <= n_wtw;
                r_wtr   <= n_wtr;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_cmd;
        end
    end

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
        r_bypd  <= wdata;
        r_byp   <= we && (waddr == raddr);
    end

endmodule

// ----- design/vlrr_checker.sv -----
// Port-level checker for the record ring, bound to the top level.
`include "variable_length_record_ring_top_assert.svh"

module vlrr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_done,
    input logic [2:0]                    o_status,
    input logic [vlrr_pkg::DATA_W-1:0]   o_data_out,
    input logic [vlrr_pkg::LEN_W-1:0]    o_length_out,
    input logic                          o_last_word,
    input logic [vlrr_pkg::CNT_W-1:0]    o_pending_messages
);
    import vlrr_pkg::*;

    // every taken word gets its strobe
    `VLRR_ASSERT_NOW(a_word_answered, start && !busy, ##3 o_done, "taken word got no result")

    // no strobe without a word taken before it
    `VLRR_ASSERT_NOW(a_no_phantom, o_done, $past(start && !busy, 3), "result without a word")

    // a rejected word returns no payload and ends no message
    `VLRR_ASSERT_NOW(a_reject_clean, o_done && (o_status != ST_OK),
        (o_data_out == '0) && (o_length_out == '0) && !o_last_word,
        "rejected word carried payload")

    // empty answer only when nothing is pending
    `VLRR_ASSERT_NOW(a_empty_pending, o_done && (o_status == ST_EMPTY),
        o_pending_messages == '0, "empty reported with messages pending")

endmodule

bind variable_length_record_ring_top vlrr_checker u_vlrr_checker (.*);
